[rtl/core/tsc_pkg.sv]
// Shared widths, codes and constant helpers for the Taylor sine and cosine core.
package tsc_pkg;

    localparam int ANGLE_W           = 23;
    localparam int VALUE_W           = 18;
    localparam int FRAC_BITS_DEFAULT = 16;

    localparam int VALUE_MAX = (1 << (VALUE_W - 1)) - 1;
    localparam int VALUE_MIN = -(1 << (VALUE_W - 1));

    // Pi with sixty fraction bits.
    localparam logic [63:0] PI_Q60 = 64'd3622009729038561421;

    typedef enum logic {
        KIND_SINE   = 1'b0,
        KIND_COSINE = 1'b1
    } kind_t;

    // How the reduction stage folds the angle back into the principal range.
    typedef enum logic [1:0] {
        RED_NONE,
        RED_SUB,
        RED_ADD
    } red_mode_t;

    // Pi rounded to nearest after dropping the given number of fraction bits.
    function automatic longint round_pi(input int drop);
        logic [63:0] sum;
        sum = PI_Q60 + (64'd1 << (drop - 1));
        return longint'(sum >> drop);
    endfunction

endpackage

[rtl/core/tsc_reduce.sv]
// Range reduction pipeline: adds pi/2 for cosine and folds the angle into [-pi, pi].
module tsc_reduce #(
    parameter int FRAC_BITS = tsc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 in_kind,
    input  logic signed [tsc_pkg::ANGLE_W-1:0]   in_angle,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [FRAC_BITS+2:0]          out_x
);
    import tsc_pkg::*;

    localparam int STAGES = 6;
    localparam int XW     = FRAC_BITS + 3;
    localparam int TW     = ((ANGLE_W > FRAC_BITS + 2) ? ANGLE_W : FRAC_BITS + 2) + 1;
    localparam int EW     = TW + 1;
    localparam int NW     = TW - 1;

    localparam longint PI_L = round_pi(60 - FRAC_BITS);
    localparam longint HP_L = round_pi(61 - FRAC_BITS);
    localparam longint TP_L = round_pi(59 - FRAC_BITS);

    localparam int TPW = $clog2(TP_L + 1);
    localparam int QW  = $clog2(((longint'(1) << NW) / TP_L) + 2);
    localparam int RW  = $clog2(2 * TP_L);
    localparam int PW  = (NW > QW + TPW) ? NW : QW + TPW;

    localparam logic signed [TW-1:0] PI_T     = TW'(PI_L);
    localparam logic signed [TW-1:0] NEG_PI_T = TW'(-PI_L);
    localparam logic signed [TW-1:0] HP_T     = TW'(HP_L);
    localparam logic signed [EW-1:0] PI_P1_E  = EW'(PI_L + 1);
    localparam logic signed [EW-1:0] NPI_P1_E = EW'(-PI_L - 1);
    localparam logic signed [EW-1:0] TP_E     = EW'(TP_L);
    localparam logic [QW-1:0]        RECIP_Q  = QW'((longint'(1) << NW) / TP_L);
    localparam logic [PW-1:0]        TP_P     = PW'(TP_L);
    localparam logic [RW-1:0]        TP_R     = RW'(TP_L);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   go;
    logic [STAGES-1:0] valid_in;

    logic signed [TW-1:0] t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic signed [TW-1:0] t1_next;
    red_mode_t            mode2_reg, mode3_reg, mode4_reg, mode5_reg;
    red_mode_t            mode2_next;
    logic [NW-1:0]        n2_reg, n3_reg, n2_next;
    logic [QW-1:0]        q3_reg, q3_next;
    logic [RW-1:0]        r4_reg, r4_next;
    logic [TPW-1:0]       rem5_reg, rem5_next;
    logic signed [XW-1:0] x6_reg, x6_next;

    logic signed [EW-1:0] up_diff, dn_diff, x_e, rem_e;
    logic [NW+QW-1:0]     qprod;
    logic [PW-1:0]        qtp, rdiff;
    logic [RW-1:0]        rsub;

    // A stage loads when it is empty or its content moves on in the same cycle.
    always_comb begin
        go[STAGES] = out_ready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            go[i] = !valid_reg[i] || go[i+1];
        end
    end

    assign valid_in  = {valid_reg[STAGES-2:0], in_valid};
    assign in_ready  = go[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_x     = x6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < STAGES; i++) begin
                if (go[i]) begin
                    valid_reg[i] <= valid_in[i];
                end
            end
        end
    end

    // Stage 1: phase offset for cosine.
    assign t1_next = TW'(in_angle) + ((in_kind == KIND_COSINE) ? HP_T : TW'(0));

    // Stage 2: decide the fold direction and the distance beyond the range.
    assign up_diff = EW'(t1_reg) - PI_P1_E;
    assign dn_diff = NPI_P1_E - EW'(t1_reg);

    always_comb begin
        if (t1_reg > PI_T) begin
            mode2_next = RED_SUB;
            n2_next    = up_diff[NW-1:0];
        end else if (t1_reg < NEG_PI_T) begin
            mode2_next = RED_ADD;
            n2_next    = dn_diff[NW-1:0];
        end else begin
            mode2_next = RED_NONE;
            n2_next    = '0;
        end
    end

    // Stage 3: quotient estimate by reciprocal; it is exact or one short.
    assign qprod   = (NW+QW)'(n2_reg) * (NW+QW)'(RECIP_Q);
    assign q3_next = qprod[NW+QW-1:NW];

    // Stage 4: partial remainder, below twice the period.
    assign qtp     = PW'(q3_reg) * TP_P;
    assign rdiff   = PW'(n3_reg) - qtp;
    assign r4_next = rdiff[RW-1:0];

    // Stage 5: one correction step gives the true remainder.
    assign rsub      = r4_reg - TP_R;
    assign rem5_next = (r4_reg >= TP_R) ? rsub[TPW-1:0] : r4_reg[TPW-1:0];

    // Stage 6: rebuild the folded angle from the remainder.
    assign rem_e = EW'($signed({1'b0, rem5_reg}));

    always_comb begin
        case (mode5_reg)
            RED_SUB: x_e = rem_e + PI_P1_E - TP_E;
            RED_ADD: x_e = TP_E - PI_P1_E - rem_e;
            default: x_e = EW'(t5_reg);
        endcase
    end

    assign x6_next = x_e[XW-1:0];

    always_ff @(posedge aclk) begin
        if (go[0]) begin
            t1_reg <= t1_next;
        end
        if (go[1]) begin
            t2_reg    <= t1_reg;
            mode2_reg <= mode2_next;
            n2_reg    <= n2_next;
        end
        if (go[2]) begin
            t3_reg    <= t2_reg;
            mode3_reg <= mode2_reg;
            n3_reg    <= n2_reg;
            q3_reg    <= q3_next;
        end
        if (go[3]) begin
            t4_reg    <= t3_reg;
            mode4_reg <= mode3_reg;
            r4_reg    <= r4_next;
        end
        if (go[4]) begin
            t5_reg    <= t4_reg;
            mode5_reg <= mode4_reg;
            rem5_reg  <= rem5_next;
        end
        if (go[5]) begin
            x6_reg <= x6_next;
        end
    end

endmodule

[rtl/core/tsc_poly.sv]
// Polynomial pipeline: nested seventh-order Taylor series and output saturation.
module tsc_poly #(
    parameter int FRAC_BITS = tsc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [FRAC_BITS+2:0]          in_x,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [tsc_pkg::VALUE_W-1:0]   out_value
);
    import tsc_pkg::*;

    localparam int STAGES = 6;
    localparam int XW     = FRAC_BITS + 3;
    localparam int X2W    = FRAC_BITS + 4;
    localparam int DS     = X2W + 6;
    localparam int MW     = DS - 2;
    localparam int AW     = X2W - 4;
    localparam int BW     = X2W - 2;
    localparam int CW     = X2W - 5;
    localparam int UW     = FRAC_BITS + 1;
    localparam int OW     = FRAC_BITS + 2;
    localparam int PW     = XW + OW;
    localparam int YW     = PW - FRAC_BITS;
    localparam int SW     = (YW > VALUE_W) ? YW : VALUE_W;

    localparam logic [MW-1:0] M6  = MW'(((longint'(1) << DS) + 5) / 6);
    localparam logic [MW-1:0] M20 = MW'(((longint'(1) << DS) + 19) / 20);
    localparam logic [MW-1:0] M42 = MW'(((longint'(1) << DS) + 41) / 42);

    localparam logic [UW-1:0]         ONE_U  = UW'(longint'(1) << FRAC_BITS);
    localparam logic signed [PW-1:0]  BIAS   = PW'((longint'(1) << FRAC_BITS) - 1);
    localparam logic signed [SW-1:0]  VMAX_S = SW'(VALUE_MAX);
    localparam logic signed [SW-1:0]  VMIN_S = SW'(VALUE_MIN);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   go;
    logic [STAGES-1:0] valid_in;

    logic [X2W-1:0]               x2_reg, x2_next;
    logic signed [XW-1:0]         xa_reg, xb_reg, xc_reg, xd_reg;
    logic [AW-1:0]                a_reg, a_next;
    logic [BW-1:0]                b_reg, b3_reg, b_next;
    logic [UW-1:0]                inner_reg, inner_next;
    logic [UW-1:0]                mid_reg, mid_next;
    logic signed [OW-1:0]         outer_reg, outer_next;
    logic signed [PW-1:0]         prod_reg, prod_next;
    logic signed [VALUE_W-1:0]    value_reg, value_next;

    logic signed [2*XW-1:0]       sq;
    logic [X2W+MW-1:0]            pa, pb, pc;
    logic [CW-1:0]                c_quo;
    logic [AW+UW-1:0]             pm;
    logic [BW+UW-1:0]             po;
    logic signed [FRAC_BITS+3:0]  outer_e;
    logic signed [PW-1:0]         biased, shifted;
    logic signed [SW-1:0]         y_s;

    always_comb begin
        go[STAGES] = out_ready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            go[i] = !valid_reg[i] || go[i+1];
        end
    end

    assign valid_in  = {valid_reg[STAGES-2:0], in_valid};
    assign in_ready  = go[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_value = value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < STAGES; i++) begin
                if (go[i]) begin
                    valid_reg[i] <= valid_in[i];
                end
            end
        end
    end

    // Stage 1: square of the angle; it is never negative, so plain truncation.
    assign sq      = (2*XW)'(in_x) * (2*XW)'(in_x);
    assign x2_next = sq[FRAC_BITS+X2W-1:FRAC_BITS];

    // Stage 2: divisions by 6, 20 and 42 as exact reciprocal products.
    assign pa         = (X2W+MW)'(x2_reg) * (X2W+MW)'(M20);
    assign pb         = (X2W+MW)'(x2_reg) * (X2W+MW)'(M6);
    assign pc         = (X2W+MW)'(x2_reg) * (X2W+MW)'(M42);
    assign a_next     = pa[DS+AW-1:DS];
    assign b_next     = pb[DS+BW-1:DS];
    assign c_quo      = pc[DS+CW-1:DS];
    assign inner_next = ONE_U - UW'(c_quo);

    // Stage 3: middle term of the nest.
    assign pm       = (AW+UW)'(a_reg) * (AW+UW)'(inner_reg);
    assign mid_next = ONE_U - UW'(pm >> FRAC_BITS);

    // Stage 4: outer term, which can go slightly negative near pi.
    assign po         = (BW+UW)'(b3_reg) * (BW+UW)'(mid_reg);
    assign outer_e    = $signed((FRAC_BITS+4)'(ONE_U)) - $signed((FRAC_BITS+4)'(po >> FRAC_BITS));
    assign outer_next = outer_e[OW-1:0];

    // Stage 5: final product, kept at full width.
    assign prod_next = PW'(xd_reg) * PW'(outer_reg);

    // Stage 6: scale with rounding toward zero, then clamp to the output range.
    assign biased  = prod_reg + (prod_reg[PW-1] ? BIAS : PW'(0));
    assign shifted = biased >>> FRAC_BITS;
    assign y_s     = SW'($signed(shifted[YW-1:0]));

    always_comb begin
        if (y_s > VMAX_S) begin
            value_next = VALUE_W'(VALUE_MAX);
        end else if (y_s < VMIN_S) begin
            value_next = VALUE_W'(VALUE_MIN);
        end else begin
            value_next = y_s[VALUE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (go[0]) begin
            x2_reg <= x2_next;
            xa_reg <= in_x;
        end
        if (go[1]) begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            inner_reg <= inner_next;
            xb_reg    <= xa_reg;
        end
        if (go[2]) begin
            mid_reg <= mid_next;
            b3_reg  <= b_reg;
            xc_reg  <= xb_reg;
        end
        if (go[3]) begin
            outer_reg <= outer_next;
            xd_reg    <= xc_reg;
        end
        if (go[4]) begin
            prod_reg <= prod_next;
        end
        if (go[5]) begin
            value_reg <= value_next;
        end
    end

endmodule

[rtl/core/taylor_sine_cosine_core.sv]
// Top level of the fixed-point Taylor sine and cosine core.
//
// Input channel (s_valid, s_ready): one word carries s_kind (0 = sine,
// 1 = cosine) and s_angle, a signed angle in radians with FRAC_BITS
// fraction bits. Result channel (m_valid, m_ready): one word carries
// m_value, the signed approximation with FRAC_BITS fraction bits, rounded
// toward zero and clamped to the 18-bit range.
// Between acceptance and m_valid, six stages fold the angle into [-pi, pi]
// and six evaluate the polynomial. Throughput is one word per cycle while
// the receiver takes results; a stalled receiver holds the pipeline.
// Reset clears every stage's valid bit; no word is in flight afterwards.
// When the receiver stalls, the result is held in the output register and
// the stages behind it keep filling empty slots; s_ready falls only once
// every stage holds a word. Words leave in the order they arrived.
module taylor_sine_cosine_core #(
    parameter int FRAC_BITS = tsc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic signed [tsc_pkg::ANGLE_W-1:0]   s_angle,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [tsc_pkg::VALUE_W-1:0]   m_value
);
    import tsc_pkg::*;

    localparam int XW = FRAC_BITS + 3;
    localparam logic signed [XW-1:0] PI_X     = XW'(round_pi(60 - FRAC_BITS));
    localparam logic signed [XW-1:0] NEG_PI_X = XW'(-round_pi(60 - FRAC_BITS));

    logic                 red_valid;
    logic                 red_ready;
    logic signed [XW-1:0] red_x;

    tsc_reduce #(
        .FRAC_BITS (FRAC_BITS)
    ) u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_kind   (s_kind),
        .in_angle  (s_angle),
        .out_valid (red_valid),
        .out_ready (red_ready),
        .out_x     (red_x)
    );

    tsc_poly #(
        .FRAC_BITS (FRAC_BITS)
    ) u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (red_valid),
        .in_ready  (red_ready),
        .in_x      (red_x),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_value (m_value)
    );

    // The folded angle handed to the polynomial always lies within [-pi, pi].
    assert property (@(posedge aclk) disable iff (!aresetn)
        red_valid |-> ((red_x <= PI_X) && (red_x >= NEG_PI_X)))
        else $error("folded angle outside [-pi, pi]");

    // Input back-pressure can only come from a full pipeline behind a stalled output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && red_valid))
        else $error("input stalled without a full pipeline");

    // Reset leaves no word in flight.
    assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !red_valid))
        else $error("word present after reset");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the Taylor sine and cosine core, with its own value predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tsc_pkg::*;

    localparam int FRAC       = FRAC_BITS_DEFAULT;
    localparam int NUM_PHASES = 4;
    localparam int PHASE_LEN  = 175;
    localparam int DRAIN_WAIT = 24;
    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_ROWS   = 24;

    typedef struct {
        kind_t                      kind;
        logic signed [ANGLE_W-1:0]  angle;
        bit                         typed;
        logic signed [VALUE_W-1:0]  value;
    } trig_row_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_kind = 1'b0;
    logic signed [ANGLE_W-1:0]  s_angle = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [VALUE_W-1:0]  m_value;

    logic signed [VALUE_W-1:0]  expected_values[$];
    int unsigned                mismatch_count = 0;
    int unsigned                cycle_count = 0;
    int unsigned                send_idle_pct = 0;
    int unsigned                recv_stall_pct = 0;

    // Directed words: extremes, both kinds, and angles either side of the fold points.
    trig_row_t trig_rows [0:NUM_ROWS-1] = '{
        '{KIND_SINE,   23'sd0,        1'b1, 18'sd0},
        '{KIND_COSINE, -23'sd102944,  1'b1, 18'sd0},
        '{KIND_SINE,   23'sd4194303,  1'b0, 18'sd0},
        '{KIND_SINE,   -23'sd4194304, 1'b0, 18'sd0},
        '{KIND_COSINE, 23'sd4194303,  1'b0, 18'sd0},
        '{KIND_COSINE, -23'sd4194304, 1'b0, 18'sd0},
        '{KIND_SINE,   23'sd205887,   1'b0, 18'sd0},
        '{KIND_SINE,   -23'sd205887,  1'b0, 18'sd0},
        '{KIND_SINE,   23'sd205888,   1'b0, 18'sd0},
        '{KIND_SINE,   -23'sd205888,  1'b0, 18'sd0},
        '{KIND_SINE,   23'sd1,        1'b0, 18'sd0},
        '{KIND_SINE,   -23'sd1,       1'b0, 18'sd0},
        '{KIND_COSINE, 23'sd0,        1'b0, 18'sd0},
        '{KIND_COSINE, 23'sd102943,   1'b0, 18'sd0},
        '{KIND_COSINE, 23'sd102944,   1'b0, 18'sd0},
        '{KIND_COSINE, -23'sd308831,  1'b0, 18'sd0},
        '{KIND_COSINE, -23'sd308832,  1'b0, 18'sd0},
        '{KIND_SINE,   23'sd411775,   1'b0, 18'sd0},
        '{KIND_SINE,   -23'sd411775,  1'b0, 18'sd0},
        '{KIND_SINE,   23'sd102944,   1'b0, 18'sd0},
        '{KIND_SINE,   -23'sd102944,  1'b0, 18'sd0},
        '{KIND_SINE,   23'sd2796202,  1'b0, 18'sd0},
        '{KIND_COSINE, -23'sd2796203, 1'b0, 18'sd0},
        '{KIND_COSINE, 23'sd1,        1'b0, 18'sd0}
    };

    taylor_sine_cosine_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .s_angle (s_angle),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_value (m_value)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Product of two fixed-point values, truncated toward zero.
    function automatic longint fixed_product(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p < 0)
            return -((-p) >>> FRAC);
        return p >>> FRAC;
    endfunction

    function automatic logic signed [VALUE_W-1:0] taylor_value(
        input kind_t kind, input logic signed [ANGLE_W-1:0] angle);
        longint x, x2, inner, mid, outer, y, unity, pi_v, half_pi_v, two_pi_v;
        pi_v      = longint'((PI_Q60 + (64'd1 << (59 - FRAC))) >> (60 - FRAC));
        half_pi_v = longint'((PI_Q60 + (64'd1 << (60 - FRAC))) >> (61 - FRAC));
        two_pi_v  = longint'((PI_Q60 + (64'd1 << (58 - FRAC))) >> (59 - FRAC));
        unity     = longint'(1) << FRAC;
        x = longint'(angle);
        if (kind == KIND_COSINE)
            x = x + half_pi_v;
        while (x > pi_v)
            x = x - two_pi_v;
        while (x < -pi_v)
            x = x + two_pi_v;
        x2    = fixed_product(x, x);
        inner = unity - x2 / 42;
        mid   = unity - fixed_product(x2 / 20, inner);
        outer = unity - fixed_product(x2 / 6, mid);
        y     = fixed_product(x, outer);
        if (y > VALUE_MAX)
            y = VALUE_MAX;
        if (y < VALUE_MIN)
            y = VALUE_MIN;
        return y[VALUE_W-1:0];
    endfunction

    // Mix of full-range angles, principal-range angles, small angles near zero and angles close to a fold point.
    function automatic logic signed [ANGLE_W-1:0] random_angle(input kind_t kind);
        int base;
        case ($urandom_range(3))
            0: return ANGLE_W'($urandom());
            1: return ANGLE_W'(int'($urandom_range(412000)) - 206000);
            2: begin
                base = (int'($urandom_range(18)) - 9) * 411775;
                base = base + (($urandom_range(1) != 0) ? 205887 : -205887);
                if (kind == KIND_COSINE)
                    base = base - 102944;
                return ANGLE_W'(base + int'($urandom_range(6)) - 3);
            end
            default: return ANGLE_W'(int'($urandom_range(4000)) - 2000);
        endcase
    endfunction

    // Present one word, idling beforehand at the current rate, and wait for acceptance.
    task automatic send_word(input kind_t kind, input logic signed [ANGLE_W-1:0] angle,
                             input bit typed, input logic signed [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_angle <= angle;
        forever begin
            @(posedge aclk);
            if (s_ready)
                break;
        end
        expected_values.push_back(typed ? value : taylor_value(kind, angle));
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (aresetn)
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        logic signed [VALUE_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_values.size() == 0) begin
                $error("value: unexpected word %0d with nothing outstanding", m_value);
                mismatch_count <= mismatch_count + 1;
            end else begin
                want = expected_values.pop_front();
                if (m_value !== want) begin
                    $error("value: expected %0d, got %0d", want, m_value);
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    initial begin
        int unsigned idle_by_phase [NUM_PHASES] = '{0, 82, 0, 18};
        int unsigned stall_by_phase [NUM_PHASES] = '{0, 0, 82, 18};
        kind_t kind;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int r = 0; r < NUM_ROWS; r++)
            send_word(trig_rows[r].kind, trig_rows[r].angle, trig_rows[r].typed,
                      trig_rows[r].value);

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = idle_by_phase[p];
            recv_stall_pct = stall_by_phase[p];
            for (int n = 0; n < PHASE_LEN; n++) begin
                kind = kind_t'($urandom_range(1));
                send_word(kind, random_angle(kind), 1'b0, '0);
            end
            // Hold the sender off until the pipeline has emptied completely.
            if (p == 1) begin
                s_valid <= 1'b0;
                while (expected_values.size() != 0)
                    @(negedge aclk);
            end
        end
        s_valid <= 1'b0;

        while (expected_values.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/core/tsc_pkg.sv
rtl/core/tsc_reduce.sv
rtl/core/tsc_poly.sv
rtl/core/taylor_sine_cosine_core.sv
tb/testbench.sv
